// ----- design/lcp_pkg.sv -----
// Package for the LED color command parser: character codes, status codes,
// the rainbow command tail and the result payload type. No dependencies.
package lcp_pkg;

  localparam int unsigned PosW   = 4;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned DigitW = 4;
  localparam int unsigned TailN  = 9;

  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChF     = 8'h46;  // 'F'
  localparam logic [7:0] ChU     = 8'h55;  // 'U'
  localparam logic [7:0] ChD     = 8'h44;  // 'D'
  localparam logic [7:0] Ch0     = 8'h30;  // '0'
  localparam logic [7:0] Ch6     = 8'h36;  // '6'
  localparam logic [7:0] Ch8     = 8'h38;  // '8'
  localparam logic [7:0] Ch9     = 8'h39;  // '9'
  localparam logic [7:0] ChLa    = 8'h61;  // 'a'
  localparam logic [7:0] ChLf    = 8'h66;  // 'f'
  localparam logic [7:0] ChUa    = 8'h41;  // 'A'

  // Positions along the command.
  localparam logic [PosW-1:0] PosWait      = 4'd0;
  localparam logic [PosW-1:0] PosHex1      = 4'd1;
  localparam logic [PosW-1:0] PosHex2      = 4'd2;
  localparam logic [PosW-1:0] PosTail1     = 4'd3;
  localparam logic [PosW-1:0] PosHex6      = 4'd6;
  localparam logic [PosW-1:0] PosD         = 4'd7;
  localparam logic [PosW-1:0] PosDigit     = 4'd8;
  localparam logic [PosW-1:0] PosTailLast  = 4'd11;

  // Letters after "#FU" in the rainbow command.
  localparam logic [7:0] RainbowTail [TailN] = '{
    8'h4C, 8'h4C, 8'h52, 8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
  };

  typedef enum logic [1:0] {
    ST_COLOR   = 2'd0,
    ST_RAINBOW = 2'd1,
    ST_ERROR   = 2'd2
  } lcp_status_e;

  typedef struct packed {
    lcp_status_e         status;
    logic [RgbW-1:0]     color_rgb;
    logic [DigitW-1:0]   led_digit;
  } lcp_result_t;

endpackage

// ----- design/lcp_if.sv -----
// Valid/ready channel interfaces: received bytes in, parse results out.
// Depends on lcp_pkg for field widths.
interface lcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcp_result_if import lcp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [RgbW-1:0]   color_rgb;
  logic [DigitW-1:0] led_digit;

  modport source (output valid, output status, output color_rgb, output led_digit,
                  input ready);
  modport sink   (input valid, input status, input color_rgb, input led_digit,
                  output ready);
endinterface

// ----- design/lcp_in_stage.sv -----
// Input register for received bytes; refills when empty or whenever the held word moves on.
// Depends on lcp_pkg (no symbols used beyond the style import).
module lcp_in_stage import lcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       ready_o,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] rx_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o   = valid_q;
  assign rx_byte_o = byte_q;

endmodule

// ----- design/lcp_parser.sv -----
// Command parse state and single-byte decode: position, color digits and
// the rainbow path flag. Depends on lcp_pkg.
module lcp_parser import lcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic [7:0]  rx_byte_i,
  output logic        emit_o,
  output lcp_result_t result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [RgbW-1:0] acc_q, acc_d;
  logic            rb_q, rb_d;

  logic [7:0]      c;
  logic [4:0]      hex;
  logic [3:0]      tail_idx;
  logic [PosW-1:0] pos_inc;

  assign c        = rx_byte_i;
  assign tail_idx = pos_q - PosTail1;
  assign pos_inc  = pos_q + 4'd1;

  // Hex value, with bit 4 set when the byte is not a hex digit.
  always_comb begin
    hex = 5'h10;
    if (c >= Ch0 && c <= Ch9) begin
      hex = {1'b0, c[3:0]};
    end else if ((c >= ChLa && c <= ChLf) || (c >= ChUa && c <= ChF)) begin
      hex = {1'b0, c[3:0] + 4'd9};
    end
  end

  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    rb_d     = rb_q;
    emit_o   = 1'b0;
    result_o = '{status: ST_ERROR, color_rgb: '0, led_digit: '0};

    if (pos_q == PosWait) begin
      if (c != ChHash) begin
        emit_o = 1'b1;
      end else begin
        pos_d = PosHex1;
      end
    end else if (pos_q == PosHex2 && rb_q && c == ChU) begin
      pos_d = PosTail1;
    end else if (pos_q >= PosTail1 && pos_q <= PosTailLast && rb_q) begin
      if (c != RainbowTail[tail_idx]) begin
        emit_o = 1'b1;
      end else if (pos_q == PosTailLast) begin
        emit_o          = 1'b1;
        result_o.status = ST_RAINBOW;
      end else begin
        pos_d = pos_inc;
      end
    end else if (pos_q >= PosHex1 && pos_q <= PosHex6) begin
      rb_d = (pos_q == PosHex1) ? (rb_q && c == ChF) : 1'b0;
      if (hex[4]) begin
        emit_o = 1'b1;
      end else begin
        acc_d = {acc_q[RgbW-5:0], hex[3:0]};
        pos_d = pos_inc;
      end
    end else if (pos_q == PosD) begin
      if (c != ChD) begin
        emit_o = 1'b1;
      end else begin
        pos_d = PosDigit;
      end
    end else if (pos_q == PosDigit) begin
      emit_o = 1'b1;
      if (c >= Ch6 && c <= Ch8) begin
        result_o = '{status: ST_COLOR, color_rgb: acc_q, led_digit: c[3:0]};
      end
    end else begin
      emit_o = 1'b1;
    end

    // Every result restarts the parse.
    if (emit_o) begin
      pos_d = PosWait;
      acc_d = '0;
      rb_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosWait;
      acc_q <= '0;
      rb_q  <= 1'b1;
    end else if (advance_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
      rb_q  <= rb_d;
    end
  end

endmodule

// ----- design/lcp_out_stage.sv -----
// Result register: holds one result until the sink takes it.
// Depends on lcp_pkg for the result type.
module lcp_out_stage import lcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  lcp_result_t result_i,
  input  logic        ready_i,
  output logic        valid_o,
  output lcp_result_t result_o
);

  logic        valid_q, valid_d;
  lcp_result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- design/led_color_command_parser.sv -----
// LED color command parser. Takes one received byte per cycle and reports
// a result when "#RRGGBBD<6..8>" or "#FULLRAINBOW" completes, or an error on
// the first byte that does not fit. A taken byte sits in the input register
// and is decoded against the parse state once the result register can take
// a word; the result it causes is then loaded into the output register.
// Throughput is one byte per cycle, set by the combinational decode against
// the parse state, and it drops only while a result waits in the output
// register and the sink is not ready.
// Depends on lcp_pkg, lcp_if and the lcp_* stage modules.
module led_color_command_parser import lcp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcp_byte_if.sink      rx_i,
  lcp_result_if.source  res_o
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        emit;
  lcp_result_t parsed;
  lcp_result_t held;

  // Decode the held byte once the result register can take a word.
  assign advance = s1_valid && (!res_o.valid || res_o.ready);

  lcp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .rx_byte_i (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .rx_byte_o (s1_byte)
  );

  lcp_parser u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (s1_byte),
    .emit_o    (emit),
    .result_o  (parsed)
  );

  lcp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (parsed),
    .ready_i  (res_o.ready),
    .valid_o  (res_o.valid),
    .result_o (held)
  );

  assign res_o.status    = held.status;
  assign res_o.color_rgb = held.color_rgb;
  assign res_o.led_digit = held.led_digit;

endmodule

// ----- design/lcp_checker.sv -----
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on lcp_pkg for status codes and widths.
module lcp_checker import lcp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic [1:0]        status_i,
  input logic [RgbW-1:0]   color_rgb_i,
  input logic [DigitW-1:0] led_digit_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (status_i == ST_COLOR || status_i == ST_RAINBOW || status_i == ST_ERROR))
    else $error("result status out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && status_i != ST_COLOR) |-> (color_rgb_i == '0 && led_digit_i == '0))
    else $error("non-color result carries color or digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && status_i == ST_COLOR) |-> (led_digit_i >= 4'd6 && led_digit_i <= 4'd8))
    else $error("color result with LED digit outside 6..8");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !ready_i) |=> (valid_i && $stable(status_i) && $stable(color_rgb_i)
                               && $stable(led_digit_i)))
    else $error("stalled result word changed");

endmodule

bind led_color_command_parser lcp_checker u_lcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (res_o.valid),
  .ready_i     (res_o.ready),
  .status_i    (res_o.status),
  .color_rgb_i (res_o.color_rgb),
  .led_digit_i (res_o.led_digit)
);
